// ----- design/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

  localparam int CNT_W = 32;
  localparam int DIST_W = 14;
  localparam int SUM_W = 16;
  localparam int IDX_W = 2;
  localparam int TRIG_W = 16;
  localparam int CM_W = 24;
  localparam int GAP_W = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PHASE_W = 3;

  localparam int SAMPLE_COUNT = 3;
  localparam logic [IDX_W-1:0] SAMPLE_LAST = IDX_W'(SAMPLE_COUNT);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int FRAC_W = 24;
  localparam int ACC_W = FRAC_W + DIST_W + 1;
  localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {(ACC_W-1){1'b0}}};

  localparam int AVG_SHIFT = 17;
  localparam int AVG_RECIP_W = AVG_SHIFT + 1;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
    AVG_RECIP_W'((2**AVG_SHIFT + SAMPLE_COUNT - 1) / SAMPLE_COUNT);
  localparam int AVG_PROD_W = SUM_W + AVG_RECIP_W;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CM_PER_TICK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_DISTANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS = 3'd4;

  localparam logic [TRIG_W-1:0] RST_TRIGGER_TICKS = 16'd10;
  localparam logic [CNT_W-1:0] RST_TIMEOUT_TICKS = 32'd1000000;
  localparam logic [CM_W-1:0] RST_CM_PER_TICK = 24'd287722;
  localparam logic [DIST_W-1:0] RST_FAULT_DISTANCE = 14'd650;
  localparam logic [GAP_W-1:0] RST_GAP_TICKS = 24'd100000;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger_ticks;
    logic [CNT_W-1:0] timeout_ticks;
    logic [CM_W-1:0] cm_per_tick;
    logic [DIST_W-1:0] fault_distance;
    logic [GAP_W-1:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo;
  } in_item_t;

  typedef struct packed {
    logic trigger;
    logic done_res;
    logic [DIST_W-1:0] average_cm;
    logic fault_seen;
    logic busy_res;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic add;
  } scale_ctl_t;

endpackage

// ----- design/uer_cfg.sv -----
// Configuration register file with reset values.
module uer_cfg
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks <= RST_TRIGGER_TICKS;
      cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
      cfg.cm_per_tick <= RST_CM_PER_TICK;
      cfg.fault_distance <= RST_FAULT_DISTANCE;
      cfg.gap_ticks <= RST_GAP_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_TICKS: cfg.trigger_ticks <= cfg_data[TRIG_W-1:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data[CNT_W-1:0];
        REG_CM_PER_TICK: cfg.cm_per_tick <= cfg_data[CM_W-1:0];
        REG_FAULT_DISTANCE: cfg.fault_distance <= cfg_data[DIST_W-1:0];
        REG_GAP_TICKS: cfg.gap_ticks <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/uer_scale.sv -----
// Echo time to distance scaler: saturating accumulator of cm per tick.
module uer_scale
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  scale_ctl_t        ctl,
  input  logic [CM_W-1:0]   cm_per_tick,
  output logic [DIST_W-1:0] dist_cm
);

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0] acc_next;

  assign acc_sum = acc + ACC_W'(cm_per_tick);

  always_comb begin
    acc_next = acc;
    if (ctl.load) begin
      acc_next = ACC_W'(cm_per_tick);
    end else if (ctl.add) begin
      acc_next = (acc_sum >= ACC_CAP) ? ACC_CAP : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  assign dist_cm = acc[ACC_W-1] ? DIST_MAX : acc[FRAC_W +: DIST_W];

`ifndef SYNTHESIS
  a_acc_capped: assert property (@(posedge clk) disable iff (rst)
    acc <= ACC_CAP)
    else $error("accumulator above cap");
  a_load_value: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> acc == ACC_W'($past(cm_per_tick)))
    else $error("accumulator load mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.load && !ctl.add |=> $stable(acc))
    else $error("accumulator moved without control");
`endif

endmodule

// ----- design/uer_fsm.sv -----
// Measurement sequencer: trigger, echo wait, echo count, gap, averaging.
module uer_fsm
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  in_item_t          item,
  input  cfg_t              cfg,
  input  logic [DIST_W-1:0] dist_cm,
  output scale_ctl_t        ctl,
  output out_item_t         res
);

  localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TRIG = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RISE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HIGH = 3'd3;
  localparam logic [PHASE_W-1:0] PH_GAP = 3'd4;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [CNT_W-1:0] tick_count;
  logic [CNT_W-1:0] tick_count_next;
  logic [IDX_W-1:0] sample_index;
  logic [IDX_W-1:0] sample_index_next;
  logic [SUM_W-1:0] sample_sum;
  logic [SUM_W-1:0] sample_sum_next;
  logic fault_flag;
  logic fault_flag_next;

  logic [CNT_W-1:0] cnt_inc;
  logic rec;
  logic rec_fault;
  logic [DIST_W-1:0] rec_dist;
  logic done;
  logic trig;
  logic load;
  logic add;
  logic [AVG_PROD_W-1:0] avg_prod;

  assign cnt_inc = (&tick_count) ? tick_count : tick_count + CNT_W'(1);
  assign rec_dist = rec_fault ? cfg.fault_distance : dist_cm;

  always_comb begin
    phase_next = phase;
    tick_count_next = tick_count;
    sample_index_next = sample_index;
    sample_sum_next = sample_sum;
    fault_flag_next = fault_flag;
    trig = 1'b0;
    rec = 1'b0;
    rec_fault = 1'b0;
    done = 1'b0;
    load = 1'b0;
    add = 1'b0;
    case (phase)
      PH_TRIG: begin
        trig = 1'b1;
        tick_count_next = cnt_inc;
        if (cnt_inc >= CNT_W'(cfg.trigger_ticks)) begin
          phase_next = PH_RISE;
          tick_count_next = '0;
        end
      end
      PH_RISE: begin
        if (item.echo) begin
          phase_next = PH_HIGH;
          tick_count_next = CNT_W'(1);
          load = 1'b1;
          if (cfg.timeout_ticks <= CNT_W'(1)) begin
            rec = 1'b1;
            rec_fault = 1'b1;
          end
        end else begin
          tick_count_next = cnt_inc;
          if (cnt_inc >= cfg.timeout_ticks) begin
            rec = 1'b1;
            rec_fault = 1'b1;
          end
        end
      end
      PH_HIGH: begin
        if (item.echo) begin
          tick_count_next = cnt_inc;
          add = 1'b1;
          if (cnt_inc >= cfg.timeout_ticks) begin
            rec = 1'b1;
            rec_fault = 1'b1;
          end
        end else begin
          rec = 1'b1;
        end
      end
      PH_GAP: begin
        tick_count_next = cnt_inc;
        if (cnt_inc >= CNT_W'(cfg.gap_ticks)) begin
          phase_next = PH_TRIG;
          tick_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (item.start_req) begin
          phase_next = PH_TRIG;
          tick_count_next = '0;
          sample_index_next = '0;
          sample_sum_next = '0;
          fault_flag_next = 1'b0;
        end
      end
    endcase
    if (rec) begin
      sample_sum_next = sample_sum + SUM_W'(rec_dist);
      fault_flag_next = fault_flag | rec_fault;
      sample_index_next = sample_index + IDX_W'(1);
      tick_count_next = '0;
      if (sample_index_next >= SAMPLE_LAST) begin
        phase_next = PH_IDLE;
        done = 1'b1;
      end else begin
        phase_next = PH_GAP;
      end
    end
  end

  assign avg_prod = AVG_PROD_W'(sample_sum_next) * AVG_PROD_W'(AVG_RECIP);

  always_comb begin
    res.trigger = trig;
    res.done_res = done;
    res.average_cm = done ? avg_prod[AVG_SHIFT +: DIST_W] : '0;
    res.fault_seen = done & fault_flag_next;
    res.busy_res = (phase_next != PH_IDLE);
  end

  assign ctl.load = step & load;
  assign ctl.add = step & add;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tick_count <= '0;
      sample_index <= '0;
      sample_sum <= '0;
      fault_flag <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      tick_count <= tick_count_next;
      sample_index <= sample_index_next;
      sample_sum <= sample_sum_next;
      fault_flag <= fault_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TRIG || phase == PH_RISE || phase == PH_HIGH || phase == PH_GAP)
      |-> sample_index < SAMPLE_LAST)
    else $error("sample index out of range while measuring");
  a_trig_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRIG |-> tick_count[CNT_W-1:TRIG_W] == '0)
    else $error("trigger count runaway");
  a_gap_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_GAP |-> tick_count[CNT_W-1:GAP_W] == '0)
    else $error("gap count runaway");
`endif

endmodule

// ----- design/ultrasonic_echo_ranger_top.sv -----
// Top level of the ultrasonic echo ranger.
//
// Each input item is one timer tick carrying start_req and the sampled echo
// level; each accepted item yields exactly one result item with the trigger
// pin level for that tick, busy_res, and on the tick a three-sample average
// completes, done_res with average_cm and fault_seen.
// Channels: in_valid/in_ready/in_data and out_valid/out_ready/out_data,
// both valid/ready. Registers are written through cfg_we/cfg_index/cfg_data
// and should only change while the block is idle.
// The result of an item is registered into out_data in the cycle after it
// is accepted. Throughput: one item per cycle unless out_ready stalls; the
// whole tick update (counter compare, echo distance accumulate, sum and
// divide-by-three multiply) sits between the state and result registers.
// Echo time is turned into centimeters by adding cm_per_tick each high tick
// into a saturating accumulator, so no wide multiplier is needed.
// Reset: synchronous; state goes idle, registers take their defaults, the
// result register empties.
// Stall: while out_ready is low and a result is held, in_ready drops and
// the state holds; with the result register empty an item is always taken.
module ultrasonic_echo_ranger_top
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  scale_ctl_t ctl;
  out_item_t res;
  logic [DIST_W-1:0] dist_cm;
  logic step;

  assign in_ready = !out_valid || out_ready;
  assign step = in_valid && in_ready;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cm_per_tick (cfg.cm_per_tick),
    .dist_cm     (dist_cm)
  );

  uer_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (in_data),
    .cfg     (cfg),
    .dist_cm (dist_cm),
    .ctl     (ctl),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while still busy");
  a_trig_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.trigger |-> !out_data.done_res && out_data.busy_res)
    else $error("trigger with done or while idle");
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");
`endif

endmodule
